// ===== rtl/smrt_pkg.sv =====
// smrt_pkg: shared types and constants for the sorted address/strength table
// no dependencies
`timescale 1ns / 1ps
package smrt_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = 48;
    localparam int MAG_W = 7;
    localparam int RPT_W = 16;
    localparam int ENTRY_W = ADDR_W + MAG_W + RPT_W;
    localparam logic [6:0] PERCENT = 7'd100;
    localparam logic [6:0] WEIGHT_RESET = 7'd50;

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_SREQ, S_SWAIT, S_SCMP, S_HMUL, S_HDIV, S_HWR,
        S_FULL, S_MRD, S_MWAIT, S_MWR, S_INS, S_OUT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [MAG_W-1:0]  mag;
    } t_job;

    // negated strength clamped to 0..127
    function automatic logic [MAG_W-1:0] to_mag(input logic signed [7:0] s);
        logic [8:0] neg;
        begin
            neg = 9'd0 - {s[7], s};
            if (s >= 0) to_mag = '0;
            else if (neg > 9'd127) to_mag = 7'd127;
            else to_mag = neg[MAG_W-1:0];
        end
    endfunction
endpackage

// ===== rtl/smrt_ram.sv =====
// smrt_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module smrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/smrt_front.sv =====
// smrt_front: accepts words, converts strength to magnitude, two-entry queue
// depends on smrt_pkg
`timescale 1ns / 1ps
module smrt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [smrt_pkg::ADDR_W-1:0] i_mac_address,
    input  logic signed [7:0]           i_signal_strength,
    output logic                        o_job_valid,
    input  logic                        i_job_ready,
    output smrt_pkg::t_job              o_job
);
    smrt_pkg::t_job r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       push, pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wr].addr <= i_mac_address;
            r_q[r_wr].mag  <= smrt_pkg::to_mag(i_signal_strength);
        end
    end
endmodule

// ===== rtl/smrt_back.sv =====
// smrt_back: binary search, running average and shift-insert over the table ram
// depends on smrt_pkg, smrt_ram
`timescale 1ns / 1ps
module smrt_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [6:0]                 i_weight,
    input  logic                       i_job_valid,
    output logic                       o_job_ready,
    input  smrt_pkg::t_job             i_job,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [6:0]                 o_entry_index,
    output logic [6:0]                 o_smoothed_magnitude,
    output logic [15:0]                o_repeat_count
);
    localparam int IW = smrt_pkg::IDX_W;
    localparam int CW = smrt_pkg::CNT_W;
    localparam int EW = smrt_pkg::ENTRY_W;
    // x/100 as (x*10486)>>20, exact for every x below 43690
    localparam logic [27:0] RECIP_100 = 28'd10486;

    smrt_pkg::t_state r_state, n_state;
    smrt_pkg::t_job   r_job;
    logic [CW-1:0] r_used, r_lo, r_hi, r_ptr, r_pos;
    logic [IW-1:0] mid;
    logic [EW-1:0] rdata, wdata;
    logic [IW-1:0] raddr, waddr;
    logic          we;
    logic [13:0]   r_prod;
    logic [27:0]   quot;
    logic [6:0]    r_newmag;
    logic [15:0]   r_newcnt;
    logic [6:0]    wgt;
    logic [1:0]    r_status;
    logic [6:0]    r_oidx, r_omag;
    logic [15:0]   r_ocnt;
    logic [smrt_pkg::ADDR_W-1:0] rd_addr;
    logic [6:0]    rd_mag;
    logic [15:0]   rd_cnt;
    logic [CW:0]   sum;

    assign sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid = sum[IW:1];
    assign {rd_addr, rd_mag, rd_cnt} = rdata;
    assign wgt = (i_weight > smrt_pkg::PERCENT) ? smrt_pkg::PERCENT : i_weight;
    assign quot = {14'd0, r_prod} * RECIP_100;

    smrt_ram #(.WIDTH(EW), .DEPTH(smrt_pkg::TABLE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            smrt_pkg::S_IDLE:  if (i_job_valid) n_state = smrt_pkg::S_SREQ;
            smrt_pkg::S_SREQ:  n_state = (r_lo < r_hi) ? smrt_pkg::S_SWAIT
                : ((r_used == CW'(smrt_pkg::TABLE_DEPTH)) ? smrt_pkg::S_FULL
                : ((r_used == r_lo) ? smrt_pkg::S_INS : smrt_pkg::S_MRD));
            smrt_pkg::S_SWAIT: n_state = smrt_pkg::S_SCMP;
            smrt_pkg::S_SCMP:  n_state = (rd_addr == r_job.addr) ? smrt_pkg::S_HMUL
                                                                : smrt_pkg::S_SREQ;
            smrt_pkg::S_HMUL:  n_state = smrt_pkg::S_HDIV;
            smrt_pkg::S_HDIV:  n_state = smrt_pkg::S_HWR;
            smrt_pkg::S_HWR:   n_state = smrt_pkg::S_OUT;
            smrt_pkg::S_FULL:  n_state = smrt_pkg::S_OUT;
            smrt_pkg::S_MRD:   n_state = smrt_pkg::S_MWAIT;
            smrt_pkg::S_MWAIT: n_state = smrt_pkg::S_MWR;
            smrt_pkg::S_MWR:   n_state = (r_ptr - CW'(1) == r_pos) ? smrt_pkg::S_INS
                                                                 : smrt_pkg::S_MRD;
            smrt_pkg::S_INS:   n_state = smrt_pkg::S_OUT;
            smrt_pkg::S_OUT:   if (i_ready) n_state = smrt_pkg::S_IDLE;
            default:           n_state = smrt_pkg::S_IDLE;
        endcase
    end

    // outputs and ram control; the read address is held until the data is used
    always_comb begin
        o_job_ready = 1'b0;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        case (r_state)
            smrt_pkg::S_IDLE:  o_job_ready = 1'b1;
            smrt_pkg::S_SREQ:  raddr = mid;
            smrt_pkg::S_SWAIT: raddr = mid;
            smrt_pkg::S_SCMP:  raddr = mid;
            smrt_pkg::S_MRD:   raddr = IW'(r_ptr - CW'(1));
            smrt_pkg::S_MWAIT: raddr = IW'(r_ptr - CW'(1));
            smrt_pkg::S_MWR: begin
                we = 1'b1; waddr = r_ptr[IW-1:0]; wdata = rdata;
            end
            smrt_pkg::S_HWR: begin
                we = 1'b1; waddr = r_pos[IW-1:0];
                wdata = {r_job.addr, r_newmag, r_newcnt};
            end
            smrt_pkg::S_INS: begin
                we = 1'b1; waddr = r_pos[IW-1:0];
                wdata = {r_job.addr, r_job.mag, 16'd1};
            end
            default: ;
        endcase
    end

    assign o_valid              = (r_state == smrt_pkg::S_OUT);
    assign o_status             = r_status;
    assign o_entry_index        = r_oidx;
    assign o_smoothed_magnitude = r_omag;
    assign o_repeat_count       = r_ocnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smrt_pkg::S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == smrt_pkg::S_INS) r_used <= r_used + CW'(1);
        end
        case (r_state)
            smrt_pkg::S_IDLE: begin
                r_job <= i_job; r_lo <= '0; r_hi <= r_used;
            end
            smrt_pkg::S_SREQ: begin
                if (r_lo < r_hi) r_pos <= CW'(mid);
                else begin r_pos <= r_lo; r_ptr <= r_used; end
            end
            smrt_pkg::S_SCMP:
                if (r_job.addr < rd_addr) r_hi <= r_pos;
                else r_lo <= r_pos + CW'(1);
            smrt_pkg::S_HMUL: begin
                r_prod <= {7'd0, rd_mag} * {7'd0, wgt}
                        + {7'd0, r_job.mag} * {7'd0, smrt_pkg::PERCENT - wgt};
                r_newcnt <= (rd_cnt == 16'hFFFF) ? rd_cnt : rd_cnt + 16'd1;
            end
            smrt_pkg::S_HDIV: r_newmag <= quot[26:20];
            smrt_pkg::S_HWR: begin
                r_status <= smrt_pkg::ST_UPDATED; r_oidx <= 7'(r_pos);
                r_omag <= r_newmag; r_ocnt <= r_newcnt;
            end
            smrt_pkg::S_FULL: begin
                r_status <= smrt_pkg::ST_FULL; r_oidx <= 7'(r_pos);
                r_omag <= '0; r_ocnt <= '0;
            end
            smrt_pkg::S_MWR: r_ptr <= r_ptr - CW'(1);
            smrt_pkg::S_INS: begin
                r_status <= smrt_pkg::ST_INSERTED; r_oidx <= 7'(r_pos);
                r_omag <= r_job.mag; r_ocnt <= 16'd1;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/sorted_mac_rssi_table.sv =====
// sorted_mac_rssi_table: top level, front queue plus search/insert engine
// depends on smrt_pkg, smrt_front, smrt_back, smrt_ram
//
// channel | signals                                        | dir
// in      | i_valid/o_ready, i_mac_address, i_signal_strength | in
// out     | o_valid/i_ready, o_status, o_entry_index,       | out
//         | o_smoothed_magnitude, o_repeat_count            |
// cfg     | i_cfg_we, i_cfg_data (history_weight)           | in
//
// a hit runs SREQ, SWAIT, SCMP per search step, then HMUL, HDIV, HWR to average
// an insert adds MRD, MWAIT, MWR per shifted entry, then INS
// the registered ram read sets these steps; one word in the engine at a time
// a two-word front queue takes up to two words while the engine or output stalls
// reset clears fill count, state, queue, weight; table contents need no clearing
`timescale 1ns / 1ps
module sorted_mac_rssi_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [47:0]        i_mac_address,
    input  logic signed [7:0]  i_signal_strength,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [6:0]         o_entry_index,
    output logic [6:0]         o_smoothed_magnitude,
    output logic [15:0]        o_repeat_count,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data
);
    logic           job_valid, job_ready;
    smrt_pkg::t_job job;
    logic [6:0]     r_weight;

    // history weight register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_weight <= smrt_pkg::WEIGHT_RESET;
        else if (i_cfg_we) r_weight <= i_cfg_data;
    end

    smrt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_mac_address(i_mac_address), .i_signal_strength(i_signal_strength),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    smrt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_weight(r_weight),
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_entry_index(o_entry_index), .o_smoothed_magnitude(o_smoothed_magnitude),
        .o_repeat_count(o_repeat_count)
    );
endmodule
